[rtl/swt_pkg.sv]
// ----------------------------------------------------------------------------
// swt_pkg
// Shared types, codes and byte constants of the shell word tokenizer.
// ----------------------------------------------------------------------------
package swt_pkg;

    // result kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // quote modes
    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_SINGLE = 2'd1;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

    // held operator codes
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_GT   = 2'd1;
    localparam logic [1:0] HELD_LT   = 2'd2;

    // byte constants
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;

    localparam int MAX_SLOTS = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } result_t;

    typedef struct packed {
        logic [2:0]                   count;
        result_t [MAX_SLOTS-1:0]      slot;
    } bundle_t;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] level;
    } queue_status_t;

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        begin
            case (c)
                CH_N:    r = CH_LF;
                CH_T:    r = CH_TAB;
                CH_R:    r = CH_CR;
                default: r = c;
            endcase
            return r;
        end
    endfunction

endpackage

[rtl/swt_if.sv]
// ----------------------------------------------------------------------------
// swt_if
// Valid/ready channels for input bytes and token results.
// ----------------------------------------------------------------------------
interface swt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_mark;

    modport source (output valid, output ch, output end_mark, input ready);
    modport sink   (input valid, input ch, input end_mark, output ready);
endinterface

interface swt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;

    modport source (output valid, output kind, output data, output last, input ready);
    modport sink   (input valid, input kind, input data, input last, output ready);
endinterface

[rtl/swt_front.sv]
// ----------------------------------------------------------------------------
// swt_front
// Classifies each byte, updates tokenizer state, builds a result bundle.
// ----------------------------------------------------------------------------
module swt_front
    import swt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic [7:0] in_ch,
    input  logic     in_end_mark,
    input  logic     q_full,
    output logic     in_ready,
    output logic     push,
    output bundle_t  bundle
);

    logic [1:0] quote_reg, quote_next;
    logic       esc_reg, esc_next;
    logic       tok_reg, tok_next;
    logic [1:0] held_reg, held_next;
    logic [2:0] n;
    logic       merged;
    logic [7:0] op;
    logic [7:0] closer;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready && (bundle.count != 3'd0);

    always_comb
    begin
        quote_next = quote_reg;
        esc_next   = esc_reg;
        tok_next   = tok_reg;
        held_next  = held_reg;
        bundle     = '0;
        n          = 3'd0;
        merged     = 1'b0;
        op         = (held_reg == HELD_GT) ? CH_GT : CH_LT;
        closer     = (quote_reg == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;

        if (in_end_mark)
        begin
            if (held_reg != HELD_NONE)
            begin
                bundle.slot[n[1:0]] = '{kind: KIND_END, data: 8'h00};
                n = n + 3'd1;
                held_next = HELD_NONE;
            end
            if (tok_reg)
            begin
                bundle.slot[n[1:0]] = '{kind: KIND_END, data: 8'h00};
                n = n + 3'd1;
                tok_next = 1'b0;
            end
            quote_next = QUOTE_NONE;
            esc_next   = 1'b0;
        end
        else
        begin
            if (held_reg != HELD_NONE)
            begin
                held_next = HELD_NONE;
                if (in_ch == op || in_ch == CH_AMP)
                begin
                    bundle.slot[n[1:0]] = '{kind: KIND_DATA, data: in_ch};
                    n = n + 3'd1;
                    bundle.slot[n[1:0]] = '{kind: KIND_END, data: 8'h00};
                    n = n + 3'd1;
                    merged = 1'b1;
                end
                else
                begin
                    bundle.slot[n[1:0]] = '{kind: KIND_END, data: 8'h00};
                    n = n + 3'd1;
                end
            end
            if (!merged)
            begin
                if (esc_reg)
                begin
                    if (!tok_next)
                    begin
                        bundle.slot[n[1:0]] = '{kind: KIND_START, data: 8'h00};
                        n = n + 3'd1;
                        tok_next = 1'b1;
                    end
                    bundle.slot[n[1:0]] = '{kind: KIND_DATA, data: unescape(in_ch)};
                    n = n + 3'd1;
                    esc_next = 1'b0;
                end
                else if (in_ch == CH_BSLASH && quote_reg != QUOTE_SINGLE)
                begin
                    esc_next = 1'b1;
                    if (!tok_next)
                    begin
                        bundle.slot[n[1:0]] = '{kind: KIND_START, data: 8'h00};
                        n = n + 3'd1;
                        tok_next = 1'b1;
                    end
                end
                else if (quote_reg != QUOTE_NONE)
                begin
                    if (in_ch == closer)
                    begin
                        quote_next = QUOTE_NONE;
                    end
                    else
                    begin
                        bundle.slot[n[1:0]] = '{kind: KIND_DATA, data: in_ch};
                        n = n + 3'd1;
                    end
                end
                else if (in_ch == CH_SPACE || in_ch == CH_TAB || in_ch == CH_LF)
                begin
                    if (tok_next)
                    begin
                        bundle.slot[n[1:0]] = '{kind: KIND_END, data: 8'h00};
                        n = n + 3'd1;
                        tok_next = 1'b0;
                    end
                end
                else if (in_ch == CH_GT || in_ch == CH_LT || in_ch == CH_PIPE
                         || in_ch == CH_AMP)
                begin
                    if (tok_next)
                    begin
                        bundle.slot[n[1:0]] = '{kind: KIND_END, data: 8'h00};
                        n = n + 3'd1;
                        tok_next = 1'b0;
                    end
                    bundle.slot[n[1:0]] = '{kind: KIND_START, data: 8'h00};
                    n = n + 3'd1;
                    bundle.slot[n[1:0]] = '{kind: KIND_DATA, data: in_ch};
                    n = n + 3'd1;
                    if (in_ch == CH_GT)
                    begin
                        held_next = HELD_GT;
                    end
                    else if (in_ch == CH_LT)
                    begin
                        held_next = HELD_LT;
                    end
                    else
                    begin
                        bundle.slot[n[1:0]] = '{kind: KIND_END, data: 8'h00};
                        n = n + 3'd1;
                    end
                end
                else if (in_ch == CH_DQUOTE || in_ch == CH_SQUOTE)
                begin
                    quote_next = (in_ch == CH_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
                    if (!tok_next)
                    begin
                        bundle.slot[n[1:0]] = '{kind: KIND_START, data: 8'h00};
                        n = n + 3'd1;
                        tok_next = 1'b1;
                    end
                end
                else
                begin
                    if (!tok_next)
                    begin
                        bundle.slot[n[1:0]] = '{kind: KIND_START, data: 8'h00};
                        n = n + 3'd1;
                        tok_next = 1'b1;
                    end
                    bundle.slot[n[1:0]] = '{kind: KIND_DATA, data: in_ch};
                    n = n + 3'd1;
                end
            end
        end
        bundle.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_reg <= QUOTE_NONE;
            esc_reg   <= 1'b0;
            tok_reg   <= 1'b0;
            held_reg  <= HELD_NONE;
        end
        else if (in_valid && in_ready)
        begin
            quote_reg <= quote_next;
            esc_reg   <= esc_next;
            tok_reg   <= tok_next;
            held_reg  <= held_next;
        end
    end

endmodule

[rtl/swt_queue.sv]
// ----------------------------------------------------------------------------
// swt_queue
// Two-entry queue of result bundles between front and back.
// ----------------------------------------------------------------------------
module swt_queue
    import swt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bundle_t       push_data,
    input  logic          pop,
    output bundle_t       head,
    output queue_status_t status
);

    bundle_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] level_reg, level_next;

    assign status.level = level_reg;
    assign status.full  = (level_reg == 2'd2);
    assign status.empty = (level_reg == 2'd0);
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        level_next  = level_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/swt_back.sv]
// ----------------------------------------------------------------------------
// swt_back
// Sends the results of the head bundle one transfer at a time.
// ----------------------------------------------------------------------------
module swt_back
    import swt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  bundle_t       head,
    input  queue_status_t status,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [1:0]    out_kind,
    output logic [7:0]    out_data,
    output logic          out_last,
    output logic          pop
);

    logic [1:0] idx_reg, idx_next;
    logic       fire;

    assign out_valid = !status.empty;
    assign out_kind  = head.slot[idx_reg].kind;
    assign out_data  = head.slot[idx_reg].data;
    assign out_last  = ({1'b0, idx_reg} == (head.count - 3'd1));
    assign fire      = out_valid && out_ready;
    assign pop       = fire && out_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (fire)
        begin
            idx_next = out_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

[rtl/shell_word_tokenizer.sv]
// ----------------------------------------------------------------------------
// shell_word_tokenizer
// Byte-serial shell command line tokenizer emitting start/data/end results.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle while the two-entry bundle queue has room.
// Each byte produces zero to four results (an operator byte after a held
// operator or an open word gives the most); results leave one per cycle
// while the output is ready, and the front stalls only when the queue
// fills. Bytes with no results (spaces between words, quote marks inside a
// word, a backslash inside a token) are accepted without pushing a bundle
// and take no output transfer. Each bundle is registered in the queue
// before its first result is offered.
module shell_word_tokenizer
    import swt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    swt_in_if.sink    in_item,
    swt_out_if.source out_item
);

    bundle_t       push_bundle;
    bundle_t       head;
    queue_status_t q_status;
    logic          push;
    logic          pop;

    swt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_item.valid),
        .in_ch       (in_item.ch),
        .in_end_mark (in_item.end_mark),
        .q_full      (q_status.full),
        .in_ready    (in_item.ready),
        .push        (push),
        .bundle      (push_bundle)
    );

    swt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_bundle),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    swt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .status    (q_status),
        .out_ready (out_item.ready),
        .out_valid (out_item.valid),
        .out_kind  (out_item.kind),
        .out_data  (out_item.data),
        .out_last  (out_item.last),
        .pop       (pop)
    );

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.level != 2'd3)
        else $error("bundle queue level out of range");

    a_no_empty_push: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_bundle.count != 3'd0 && push_bundle.count <= 3'd4))
        else $error("bundle pushed with bad result count");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_item.valid && out_item.kind != KIND_DATA) |-> out_item.data == 8'h00)
        else $error("non-data result carries data");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid |-> out_item.kind != 2'd3)
        else $error("illegal result kind");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule
